// ===== sv/pspd_pkg.sv =====
package pspd_pkg;

	// Palette store size and the address bits it needs
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// Item operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Line control bit positions
	localparam int CTL_MODE640_BIT = 7;
	localparam int CTL_FILL_BIT    = 5;

	typedef logic [11:0] color_t;

	// Widen a 4-bit channel to 8 bits: n * 17 is the nibble repeated
	function automatic logic [7:0] widen(input logic [3:0] n);
		return {n, n};
	endfunction

	// True where an entry index falls inside the store
	function automatic logic in_store(input logic [7:0] idx);
		return {1'b0, idx} < 9'(PALETTE_ENTRIES);
	endfunction

endpackage

// ===== sv/palette_scanline_pixel_decode_unit.sv =====
// Palette scanline pixel decoder.
// Source channel (src_valid / src_stall): one item per transfer. op selects a
// palette entry write (entry_index, color_word) or the decode of one bitmap
// byte (pixel_byte) under line_control, with line_start on a line's first byte.
// Pixel channel (pix_valid / pix_stall): one pixel per transfer, red, green and
// blue widened to 8 bits, last_pixel on the final pixel of the byte.
// A 320 mode byte gives 2 pixels, a 640 mode byte gives 4, a write gives none.
// A taken byte passes the job stage, the read stage and the output register
// before its first pixel is offered. The memory port issues one read per pixel
// per cycle unless stalled, so a byte holds the job stage for all its reads.
// A new item is taken in the same cycle as the last read of the one before it.
// Reset clears the per-entry written flags and the fill colour, so the whole
// store reads as zero at once; no clearing pass is needed and items are taken
// from the first cycle after reset.
// While the receiver stalls a waiting pixel, the output register, the read
// stage and the job stage hold; an item is still taken if the job stage is free.
module palette_scanline_pixel_decode_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic        op,
	input  logic [7:0]  entry_index,
	input  logic [11:0] color_word,
	input  logic [7:0]  line_control,
	input  logic [7:0]  pixel_byte,
	input  logic        line_start,
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_pixel
);

	localparam int AW = pspd_pkg::PAL_AW;

	// Palette memory and per-entry written flags
	pspd_pkg::color_t mem [pspd_pkg::PALETTE_ENTRIES];
	logic [pspd_pkg::PALETTE_ENTRIES-1:0] wvalid_q;

	// Job stage
	logic        valid_s1;
	logic        op_s1;
	logic        mode640_s1;
	logic        fill_s1;
	logic [3:0]  pal_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [7:0]  entry_s1;
	logic [11:0] color_s1;
	logic [1:0]  step_s1;

	// Read stage
	logic             valid_s2;
	logic             last_s2;
	logic             mode640_s2;
	logic             use_fill_s2;
	logic             load_b_s2;
	logic             ok_a_s2;
	logic             ok_b_s2;
	pspd_pkg::color_t rdata_a_s2;
	pspd_pkg::color_t rdata_b_s2;

	// Output stage
	logic       valid_s3;
	logic [7:0] red_s3;
	logic [7:0] green_s3;
	logic [7:0] blue_s3;
	logic       last_s3;

	pspd_pkg::color_t fill_q;

	logic             adv;
	logic             issue;
	logic             take;
	logic             last_step;
	logic [1:0]       pair;
	logic [3:0]       idx;
	logic [7:0]       rd_addr;
	logic [7:0]       base_addr;
	logic             use_fill;
	logic             load_b;
	logic             wr_en;
	logic             rd_en;
	pspd_pkg::color_t color_s2;

	// Advance the whole pipe unless a pixel waits on a stalled receiver
	assign adv       = !(valid_s3 && pix_stall);
	assign issue     = adv && valid_s1;
	assign last_step = (op_s1 == pspd_pkg::OP_WRITE) ||
		(mode640_s1 ? (step_s1 == 2'd3) : (step_s1 == 2'd1));
	assign src_stall = valid_s1 && !(issue && last_step);
	assign take      = src_valid && !src_stall;
	assign wr_en     = issue && (op_s1 == pspd_pkg::OP_WRITE) && pspd_pkg::in_store(entry_s1);
	assign rd_en     = issue && (op_s1 == pspd_pkg::OP_DECODE);

	// Form the palette address for the current pixel
	always_comb begin
		case (step_s1)
			2'd0:    pair = byte_s1[7:6];
			2'd1:    pair = byte_s1[5:4];
			2'd2:    pair = byte_s1[3:2];
			default: pair = byte_s1[1:0];
		endcase
		if (mode640_s1) begin
			idx = {step_s1, pair};
		end else begin
			idx = step_s1[0] ? byte_s1[3:0] : byte_s1[7:4];
		end
		rd_addr   = {pal_s1, idx};
		base_addr = {pal_s1, 4'h0};
		// A line start with fill and a zero first index reads colour 0 directly
		use_fill  = !mode640_s1 && fill_s1 && (idx == 4'h0) &&
			!(start_s1 && (step_s1 == 2'd0));
		load_b    = mode640_s1 && start_s1 && (step_s1 == 2'd0);
	end

	// Hold the job, step through its pixels, release on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_s1  <= 2'd0;
		end else if (take) begin
			valid_s1 <= 1'b1;
			step_s1  <= 2'd0;
		end else if (issue && last_step) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			step_s1 <= step_s1 + 2'd1;
		end
	end

	// Load the job payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1      <= op;
			mode640_s1 <= line_control[pspd_pkg::CTL_MODE640_BIT];
			fill_s1    <= line_control[pspd_pkg::CTL_FILL_BIT];
			pal_s1     <= line_control[3:0];
			byte_s1    <= pixel_byte;
			start_s1   <= line_start;
			entry_s1   <= entry_index;
			color_s1   <= color_word;
		end
	end

	// Write the palette, read the pixel entry and colour 0 of the line's palette
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[entry_s1[AW-1:0]] <= color_s1;
		end
		if (rd_en) begin
			rdata_a_s2 <= mem[rd_addr[AW-1:0]];
			rdata_b_s2 <= mem[base_addr[AW-1:0]];
			ok_a_s2    <= pspd_pkg::in_store(rd_addr) && wvalid_q[rd_addr[AW-1:0]];
			ok_b_s2    <= pspd_pkg::in_store(base_addr) && wvalid_q[base_addr[AW-1:0]];
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (wr_en) begin
			wvalid_q[entry_s1[AW-1:0]] <= 1'b1;
		end
	end

	// Carry pixel control alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_s2     <= last_step;
			mode640_s2  <= mode640_s1;
			use_fill_s2 <= use_fill;
			load_b_s2   <= load_b;
		end
	end

	// Pick the pixel colour: fill colour, the entry read, or zero if never written
	assign color_s2 = use_fill_s2 ? fill_q : (ok_a_s2 ? rdata_a_s2 : '0);

	// Update the fill colour as pixels leave the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv && valid_s2) begin
			if (!mode640_s2) begin
				fill_q <= color_s2;
			end else if (load_b_s2) begin
				fill_q <= ok_b_s2 ? rdata_b_s2 : '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			red_s3   <= pspd_pkg::widen(color_s2[11:8]);
			green_s3 <= pspd_pkg::widen(color_s2[7:4]);
			blue_s3  <= pspd_pkg::widen(color_s2[3:0]);
			last_s3  <= last_s2;
		end
	end

	assign pix_valid  = valid_s3;
	assign red        = red_s3;
	assign green      = green_s3;
	assign blue       = blue_s3;
	assign last_pixel = last_s3;

	// A palette write never produces a pixel
	a_write_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (op_s1 == pspd_pkg::OP_WRITE)) |=> !valid_s2)
		else $error("palette write produced a pixel");

	// Only the final pixel of a byte carries the last flag
	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !last_step) |=> (valid_s2 && !last_s2))
		else $error("last flag on an inner pixel");

	// The fill colour holds while the receiver stalls a pixel
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && pix_stall) |=> $stable(fill_q))
		else $error("fill colour moved during a stall");

	// A 320 mode job never steps beyond its second pixel
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == pspd_pkg::OP_DECODE) && !mode640_s1) |-> (step_s1[1] == 1'b0))
		else $error("320 mode step out of range");

endmodule
